### design/char_lcd_nibble_write_queue_core_assert.svh
// ----------------------------------------------------------------------------
// char lcd write queue assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_QUEUE_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_QUEUE_CORE_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define LCDQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdq check failed");

// antecedent holds, consequent holds in the next cycle
`define LCDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdq check failed");

`endif

### design/lcdq_pkg.sv
// ----------------------------------------------------------------------------
// lcdq_pkg
// types, codes and constants of the char lcd write queue
// ----------------------------------------------------------------------------
`default_nettype none

package lcdq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned BYTES_PER_XFER  = 4;
    localparam int unsigned ENTRY_W         = 9;
    localparam int unsigned CFG_INDEX_W     = 1;
    localparam int unsigned CFG_DATA_W      = 3;

    localparam logic [7:0] DDRAM_SET     = 8'h80;
    localparam logic [2:0] ROW_LIMIT_MAX = 3'd4;

    typedef enum logic [1:0] {
        CMD_WRITE_CHAR = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_XFER_DONE  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BACKLIGHT = 1'b0,
        REG_ROW_COUNT = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD
    } t_state;

    // one byte slot of the output chain
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_cell;

    // queue entry: select in bit 8, byte below
    typedef struct packed {
        logic       sel;
        logic [7:0] value;
    } t_entry;

    function automatic logic [7:0] row_offset(input logic [1:0] idx);
        logic [7:0] off;
        unique case (idx)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = 8'h14;
            default: off = 8'h54;
        endcase
        return off;
    endfunction

    // expander byte: nibble, backlight, enable, zero, select
    function automatic logic [7:0] exp_byte(input logic [3:0] nib, input logic bl,
                                            input logic en, input logic sel);
        return {nib, bl, en, 1'b0, sel};
    endfunction

endpackage

`default_nettype wire

### design/lcdq_cell.sv
// ----------------------------------------------------------------------------
// lcdq_cell
// one byte slot of the output chain, loads in parallel, shifts to its neighbour
// ----------------------------------------------------------------------------
`default_nettype none

module lcdq_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  wire               i_shift,
    input  wire lcdq_pkg::t_cell i_load_cell,
    input  wire               i_next_valid,
    input  wire lcdq_pkg::t_cell i_next_cell,
    output logic              o_valid,
    output lcdq_pkg::t_cell   o_cell
);
    import lcdq_pkg::*;

    logic  r_valid;
    t_cell r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_shift) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cell <= i_load_cell;
        end else if (i_shift) begin
            r_cell <= i_next_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

`default_nettype wire

### design/lcdq_queue.sv
// ----------------------------------------------------------------------------
// lcdq_queue
// circular entry queue with one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lcdq_queue #(
    parameter int unsigned DEPTH = lcdq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire lcdq_pkg::t_entry i_push_entry,
    input  wire               i_pop,
    output logic              o_empty,
    output lcdq_pkg::t_entry  o_rd_entry
);
    import lcdq_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_entry           r_mem [DEPTH];
    t_entry           r_rd_entry;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             w_full;

    assign n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
    assign w_full   = (n_wr_ptr == r_rd_ptr);
    assign o_empty  = (r_wr_ptr == r_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !w_full) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !w_full) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
        if (i_pop) begin
            r_rd_entry <= r_mem[r_rd_ptr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

`default_nettype wire

### design/char_lcd_nibble_write_queue_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_queue_core
// queues lcd writes and sends each as four expander bytes over a stream
// ----------------------------------------------------------------------------
// write-character and set-cursor requests enter a queue of QUEUE_DEPTH
// entries (one slot stays unused, a request to a full queue is dropped);
// a request to an idle block or a transfer-done request starts a transfer,
// which pops one entry and emits four bytes on the master side, the last
// one flagged by tlast. a push to a busy block or an unknown command is
// only accepted; a transfer-done request that finds the queue empty goes
// through accept and queue check; one that starts a transfer goes through
// accept, queue check and memory read, and load before the next request is
// accepted, and its four bytes leave a chain of four byte cells at one byte
// per cycle while i_m_tready is high. the loading of a new transfer waits
// until the chain has drained, so back-to-back transfers are spaced by the
// draining and the loading of the chain. configuration writes take effect
// at once and belong only where no request is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_queue_core #(
    parameter int unsigned QUEUE_DEPTH = lcdq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [23:0]                         i_s_tdata,   // char_code, column, row, pad
    input  wire  [1:0]                          i_s_tuser,   // command
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [7:0]                          o_m_tdata,   // expander_byte
    output logic                                o_m_tlast,
    input  wire                                 i_cfg_we,
    input  wire  [lcdq_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire  [lcdq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import lcdq_pkg::*;

    localparam int unsigned NC = BYTES_PER_XFER;

    t_state     r_state;
    t_state     n_state;
    logic       r_busy;
    logic       r_backlight;
    logic [2:0] r_row_count;

    t_cmd       w_cmd;
    logic [7:0] w_char;
    logic [6:0] w_col;
    logic [7:0] w_row;
    logic       w_accept;
    logic       w_push;
    logic       w_start;
    logic       w_pop;
    logic       w_load;
    logic       w_empty;
    logic       w_shift;
    logic       w_chain_empty;
    t_entry     w_push_entry;
    t_entry     w_rd_entry;
    logic [2:0] w_limit;
    logic [1:0] w_row_idx;
    logic [7:0] w_cursor;

    logic  [NC-1:0] w_valid;
    t_cell          w_cell      [NC];
    t_cell          w_load_cell [NC];

    assign w_cmd    = t_cmd'(i_s_tuser);
    assign w_char   = i_s_tdata[7:0];
    assign w_col    = i_s_tdata[14:8];
    assign w_row    = i_s_tdata[22:15];
    assign w_accept = i_s_tvalid && o_s_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b1;
            r_row_count <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_BACKLIGHT: r_backlight <= i_cfg_wdata[0];
                REG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                default:       r_row_count <= r_row_count;
            endcase
        end
    end

    // row clamp and cursor command
    always_comb begin
        if (r_row_count == 3'd0) begin
            w_limit = 3'd1;
        end else if (r_row_count > ROW_LIMIT_MAX) begin
            w_limit = ROW_LIMIT_MAX;
        end else begin
            w_limit = r_row_count;
        end
        if (w_row >= {5'd0, w_limit}) begin
            w_row_idx = 2'(w_limit - 3'd1);
        end else begin
            w_row_idx = w_row[1:0];
        end
        w_cursor = DDRAM_SET | ({1'b0, w_col} + row_offset(w_row_idx));
    end

    always_comb begin
        w_push       = 1'b0;
        w_start      = 1'b0;
        w_push_entry = '{sel: 1'b1, value: w_char};
        case (w_cmd)
            CMD_WRITE_CHAR: begin
                w_push  = w_accept;
                w_start = w_accept && !r_busy;
            end
            CMD_SET_CURSOR: begin
                w_push       = w_accept;
                w_start      = w_accept && !r_busy;
                w_push_entry = '{sel: 1'b0, value: w_cursor};
            end
            CMD_XFER_DONE: begin
                w_start = w_accept;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_start) n_state = ST_CHECK;
            ST_CHECK: n_state = w_empty ? ST_IDLE : ST_LOAD;
            ST_LOAD:  if (w_chain_empty) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_pop      = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_s_tready = 1'b1;
            ST_CHECK: w_pop = !w_empty;
            ST_LOAD:  w_load = w_chain_empty;
            default:  o_s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CHECK) begin
                r_busy <= !w_empty;
            end
        end
    end

    lcdq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .i_pop        (w_pop),
        .o_empty      (w_empty),
        .o_rd_entry   (w_rd_entry)
    );

    // four bytes of one transfer
    always_comb begin
        w_load_cell[0] = '{last: 1'b0, data: exp_byte(w_rd_entry.value[7:4], r_backlight,
                                                      1'b1, w_rd_entry.sel)};
        w_load_cell[1] = '{last: 1'b0, data: exp_byte(w_rd_entry.value[7:4], r_backlight,
                                                      1'b0, w_rd_entry.sel)};
        w_load_cell[2] = '{last: 1'b0, data: exp_byte(w_rd_entry.value[3:0], r_backlight,
                                                      1'b1, w_rd_entry.sel)};
        w_load_cell[3] = '{last: 1'b1, data: exp_byte(w_rd_entry.value[3:0], r_backlight,
                                                      1'b0, w_rd_entry.sel)};
    end

    assign w_shift       = !w_valid[0] || i_m_tready;
    assign w_chain_empty = ~|w_valid;

    for (genvar k = 0; k < NC; k++) begin : g_chain
        if (k == NC - 1) begin : g_tail
            lcdq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (w_load),
                .i_shift      (w_shift),
                .i_load_cell  (w_load_cell[k]),
                .i_next_valid (1'b0),
                .i_next_cell  ('0),
                .o_valid      (w_valid[k]),
                .o_cell       (w_cell[k])
            );
        end else begin : g_body
            lcdq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (w_load),
                .i_shift      (w_shift),
                .i_load_cell  (w_load_cell[k]),
                .i_next_valid (w_valid[k+1]),
                .i_next_cell  (w_cell[k+1]),
                .o_valid      (w_valid[k]),
                .o_cell       (w_cell[k])
            );
        end
    end

    assign o_m_tvalid = w_valid[0];
    assign o_m_tdata  = w_cell[0].data;
    assign o_m_tlast  = w_cell[0].last;

endmodule

`default_nettype wire

### design/char_lcd_nibble_write_queue_core_checker.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_queue_core_checker
// port-level checks of the char lcd write queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_write_queue_core_assert.svh"

module char_lcd_nibble_write_queue_core_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    input  wire                                 o_s_tready,
    input  wire  [1:0]                          i_s_tuser,
    input  wire                                 o_m_tvalid,
    input  wire                                 i_m_tready,
    input  wire  [7:0]                          o_m_tdata,
    input  wire                                 o_m_tlast
);
    import lcdq_pkg::*;

    logic w_in_acc;
    logic w_out_acc;
    logic w_stall;
    logic w_form_ok;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;
    assign w_stall   = o_m_tvalid && !i_m_tready;
    assign w_form_ok = !o_m_tdata[1] && (!o_m_tlast || !o_m_tdata[2]);

    // stalled byte stays put
    `LCDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_m_tvalid && $stable({o_m_tdata, o_m_tlast}))

    // the bytes of one transfer follow without a gap
    `LCDQ_ASSERT_NEXT(a_burst_gapless, i_clk, i_rst_n, w_out_acc && !o_m_tlast, o_m_tvalid)

    // a transfer-done request keeps the block busy for the queue check
    `LCDQ_ASSERT_NEXT(a_done_blocks, i_clk, i_rst_n, w_in_acc && (i_s_tuser == CMD_XFER_DONE), !o_s_tready)

    // every byte carries enable low on its last byte, bit one always clear
    `LCDQ_ASSERT_SAME(a_byte_form, i_clk, i_rst_n, o_m_tvalid, w_form_ok)

endmodule

bind char_lcd_nibble_write_queue_core char_lcd_nibble_write_queue_core_checker u_checker (.*);

`default_nettype wire
